>>> src/otlc_pkg.sv
// Shared types and constants for the ordering table link compactor.
// No dependencies; imported by every module under src.
package otlc_pkg;

  localparam int DEPTH     = 256;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int SIZE_W    = IDX_W + 1;
  localparam int WORD_W    = 32;
  localparam int MIN_TABLE = 8;
  localparam int CFG_IDX_W = 1;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [SIZE_W-1:0] size_t;
  typedef logic [WORD_W-1:0] word_t;
  typedef logic [1:0]        func_t;
  typedef logic [7:0]        count_t;

  localparam func_t FUNC_WRITE   = 2'd0;
  localparam func_t FUNC_READ    = 2'd1;
  localparam func_t FUNC_COMPACT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDR  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE = 1'd1;

endpackage

>>> src/otlc_link_cmp.sv
// Link compare unit: checks whether a table word points at a given slot.
// Depends on otlc_pkg.
module otlc_link_cmp (
  input  otlc_pkg::word_t base_addr,
  input  otlc_pkg::idx_t  pos,
  input  otlc_pkg::word_t word,
  output logic            match
);
  import otlc_pkg::*;

  word_t slot_addr;

  assign slot_addr = base_addr + word_t'({pos, 2'b00});
  assign match     = (word == slot_addr);

endmodule

>>> src/otlc_seq.sv
// Sequencer, link table memory and output register of the compactor.
// Depends on otlc_pkg; uses the external otlc_link_cmp through cmp_* ports.
module otlc_seq (
  input  logic                       clk,
  input  logic                       rst,
  input  otlc_pkg::word_t            base_addr,
  input  otlc_pkg::size_t            table_size,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  otlc_pkg::func_t            func,
  input  otlc_pkg::idx_t             index,
  input  otlc_pkg::word_t            value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output otlc_pkg::word_t            data,
  output otlc_pkg::count_t           skipped,
  output otlc_pkg::idx_t             cmp_pos,
  output otlc_pkg::word_t            cmp_word,
  input  logic                       cmp_match
);
  import otlc_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_RD_WAIT = 3'd1;
  localparam logic [2:0] S_INIT    = 3'd2;
  localparam logic [2:0] S_OUTER   = 3'd3;
  localparam logic [2:0] S_INNER   = 3'd4;
  localparam logic [2:0] S_DONE    = 3'd5;

  word_t  mem [DEPTH];
  word_t  rdata;

  logic [2:0] state, state_next;
  idx_t   pos, pos_next;
  idx_t   dst, dst_next;
  count_t cnt, cnt_next;
  word_t  res_data, res_data_next;
  count_t res_skip, res_skip_next;

  idx_t   pos_dec;
  size_t  n_eff;
  idx_t   raddr;
  idx_t   waddr;
  word_t  wdata;
  logic   we;
  logic   out_free;

  assign pos_dec  = pos - 1'b1;
  assign n_eff    = (table_size > size_t'(DEPTH)) ? size_t'(DEPTH) : table_size;
  assign cmp_pos  = pos_dec;
  assign cmp_word = rdata;
  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next    = state;
    pos_next      = pos;
    dst_next      = dst;
    cnt_next      = cnt;
    res_data_next = res_data;
    res_skip_next = res_skip;
    raddr         = pos_dec;
    we            = 1'b0;
    waddr         = dst;
    wdata         = rdata;
    unique case (state)
      S_IDLE: begin
        raddr = index;
        if (in_valid) begin
          res_data_next = '0;
          res_skip_next = '0;
          case (func)
            FUNC_WRITE: begin
              we         = 1'b1;
              waddr      = index;
              wdata      = value;
              state_next = S_DONE;
            end
            FUNC_READ:    state_next = S_RD_WAIT;
            FUNC_COMPACT: state_next = S_INIT;
            default:      state_next = S_DONE;
          endcase
        end
      end
      S_RD_WAIT: begin
        res_data_next = rdata;
        state_next    = S_DONE;
      end
      S_INIT: begin
        cnt_next = '0;
        if (n_eff < size_t'(MIN_TABLE)) begin
          state_next = S_DONE;
        end else begin
          pos_next   = idx_t'(n_eff - 1'b1);
          raddr      = idx_t'(n_eff - 1'b1);
          state_next = S_OUTER;
        end
      end
      S_OUTER: begin
        // rdata holds the link of entry pos
        pos_next = pos_dec;
        dst_next = pos;
        if (pos_dec == '0) begin
          res_skip_next = cmp_match ? '0 : cnt;
          state_next    = S_DONE;
        end else if (cmp_match) begin
          state_next = S_INNER;
        end
      end
      S_INNER: begin
        // rdata holds the link of entry pos inside an empty run
        pos_next = pos_dec;
        if (pos_dec == '0) begin
          we            = 1'b1;
          res_skip_next = cnt;
          state_next    = S_DONE;
        end else begin
          cnt_next = cnt + 1'b1;
          if (!cmp_match) begin
            we         = 1'b1;
            state_next = S_OUTER;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
    pos      <= pos_next;
    dst      <= dst_next;
    cnt      <= cnt_next;
    res_data <= res_data_next;
    res_skip <= res_skip_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      data    <= res_data;
      skipped <= res_skip;
    end
  end

`ifndef ASSERT_OFF
  a_write_states: assert property (@(posedge clk) disable iff (rst)
    we |-> (state == S_IDLE || state == S_INNER))
    else $error("table write outside idle or run walk");

  a_walk_pos: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUTER || state == S_INNER) |-> pos != '0)
    else $error("walk reached entry zero without finishing");

  a_relink_above: assert property (@(posedge clk) disable iff (rst)
    state == S_INNER |-> dst > pos)
    else $error("relink target not above walk position");

  a_done_handoff: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_free) |=> (out_valid && state == S_IDLE))
    else $error("result not handed to output register");
`endif

endmodule

>>> src/ordering_table_link_compactor.sv
// Top level of the ordering table link compactor: ports, config registers.
// Depends on otlc_pkg, otlc_link_cmp and otlc_seq.
//
//   channel   direction  payload
//   s_axis    in         tuser: func; tdata: index, value
//   m_axis    out        tdata: data, skipped
//   cfg       in         cfg_index 0 base_addr, 1 table_size
//
// Write: table write, then the output register. Read: table read, registered read
// data, then the output register. Compaction: one table read per visited entry
// through the single read port of the link memory; tables under 8 skip the walk.
// rst is synchronous; the table itself is not cleared and holds junk until written.
// s_axis_tready is low while an item is in work; a held result stalls only
// the final step.
module ordering_table_link_compactor (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [39:0]                       s_axis_tdata,  // index[7:0], value[39:8]
  input  logic [1:0]                        s_axis_tuser,  // func[1:0]
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [39:0]                       m_axis_tdata,  // data[31:0], skipped[39:32]
  input  logic                              cfg_we,
  input  logic [otlc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [31:0]                       cfg_data
);
  import otlc_pkg::*;

  word_t  base_addr;
  size_t  table_size;
  idx_t   cmp_pos;
  word_t  cmp_word;
  logic   cmp_match;
  word_t  out_data;
  count_t out_skipped;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_addr  <= '0;
      table_size <= size_t'(DEPTH);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BASE_ADDR:  base_addr  <= cfg_data;
        REG_TABLE_SIZE: table_size <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  otlc_link_cmp u_cmp (
    .base_addr (base_addr),
    .pos       (cmp_pos),
    .word      (cmp_word),
    .match     (cmp_match)
  );

  otlc_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .base_addr  (base_addr),
    .table_size (table_size),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .func       (s_axis_tuser),
    .index      (s_axis_tdata[7:0]),
    .value      (s_axis_tdata[39:8]),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .data       (out_data),
    .skipped    (out_skipped),
    .cmp_pos    (cmp_pos),
    .cmp_word   (cmp_word),
    .cmp_match  (cmp_match)
  );

  assign m_axis_tdata = {out_skipped, out_data};

endmodule
